FILE: src/lzd_pkg.sv
// shared types and constants for the escape-coded lz decompressor
`default_nettype none

package lzd_pkg;

    localparam int WINDOW_DEPTH = 65536;
    localparam int QUEUE_DEPTH  = 4;
    localparam int SRC_W        = 32;
    localparam int LEN_W        = 14;
    localparam int DIST_W       = 25;

    typedef enum logic [2:0] {
        ST_NONE  = 3'd0,
        ST_BYTE  = 3'd1,
        ST_BUSY  = 3'd2,
        ST_IDLE  = 3'd3,
        ST_MODE  = 3'd4,
        ST_FAR   = 3'd5,
        ST_TRUNC = 3'd6
    } t_status;

    typedef struct packed {
        logic       func;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // command from the parser to the history side
    typedef struct packed {
        t_status           status;
        logic [7:0]        data;
        logic              last;
        logic              hist_wr;
        logic              from_mem;
        logic [DIST_W-1:0] distance;
    } t_cmd;

endpackage

`default_nettype wire

FILE: src/lzd_fifo.sv
// small register queue used between the parser, the history side and the result port
`default_nettype none

module lzd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lzd_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd, r_wr;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= ptr_inc(r_wr);
            if (do_pop)  r_rd <= ptr_inc(r_rd);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

`default_nettype wire

FILE: src/lzd_front.sv
// token parser: header, escape codes, match setup and window fill tracking
`default_nettype none

module lzd_front #(
    parameter int WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire lzd_pkg::t_in_item i_item,
    output lzd_pkg::t_cmd        o_cmd
);

    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = lzd_pkg::SRC_W;
    localparam int LW = lzd_pkg::LEN_W;
    localparam int DW = lzd_pkg::DIST_W;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_PLAIN  = 7'b0000010,
        PH_CODE   = 7'b0000100,
        PH_EXT    = 7'b0001000,
        PH_DIST   = 7'b0010000,
        PH_COPY   = 7'b0100000,
        PH_DRAIN  = 7'b1000000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [3:0]    r_hdr_idx, n_hdr_idx;
    logic [SW-1:0] r_src_left, n_src_left;
    logic [7:0]    r_key, n_key;
    logic [1:0]    r_dmode, n_dmode;
    logic [1:0]    r_dpos, n_dpos;
    logic [LW-1:0] r_len, n_len;
    logic [DW-1:0] r_dist, n_dist;
    logic [FW-1:0] r_filled, n_filled;

    logic [7:0]    b, code;
    logic          blk_end, do_plain, do_trunc, hist_push;
    logic [DW-1:0] dist_or, dist_fin;
    lzd_pkg::t_cmd cmd;

    assign b = i_item.in_byte;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_src_left = r_src_left;
        n_key      = r_key;
        n_dmode    = r_dmode;
        n_dpos     = r_dpos;
        n_len      = r_len;
        n_dist     = r_dist;
        n_filled   = r_filled;
        do_plain   = 1'b0;
        do_trunc   = 1'b0;
        hist_push  = 1'b0;

        cmd          = '0;
        cmd.status   = lzd_pkg::ST_NONE;
        cmd.distance = r_dist;

        // block ends on this byte when one source byte remains
        blk_end  = (r_src_left == SW'(1));
        code     = (b > r_key) ? b - 8'd1 : b;
        dist_or  = r_dist | (DW'(b) << {r_dpos, 3'b000});
        dist_fin = dist_or + DW'(1);

        if (i_item.func) begin
            if (r_phase == PH_COPY) begin
                cmd.status   = lzd_pkg::ST_BYTE;
                cmd.hist_wr  = 1'b1;
                cmd.from_mem = 1'b1;
                hist_push    = 1'b1;
                n_len        = r_len - LW'(1);
                if (r_len == LW'(1)) begin
                    cmd.last = (r_src_left == '0);
                    n_phase  = (r_src_left == '0) ? PH_HEADER : PH_PLAIN;
                end
            end else begin
                cmd.status = lzd_pkg::ST_IDLE;
            end
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_idx >= 4'd8) begin
                        n_key      = b;
                        n_src_left = r_src_left - SW'(9);
                        n_filled   = '0;
                        n_hdr_idx  = '0;
                        n_phase    = (r_src_left == SW'(9)) ? PH_HEADER : PH_PLAIN;
                    end else begin
                        n_hdr_idx = r_hdr_idx + 4'd1;
                        if (r_hdr_idx == 4'd0) n_src_left = '0;
                        if (r_hdr_idx[3:2] == 2'b01) n_src_left[{r_hdr_idx[1:0], 3'b000} +: 8] = b;
                    end
                end
                PH_PLAIN: begin
                    n_src_left = r_src_left - SW'(1);
                    if (b != r_key) do_plain = 1'b1;
                    else if (blk_end) do_trunc = 1'b1;
                    else n_phase = PH_CODE;
                end
                PH_CODE: begin
                    n_src_left = r_src_left - SW'(1);
                    if (b == r_key) begin
                        do_plain = 1'b1;
                    end else begin
                        n_len   = LW'(code >> 3);
                        n_dist  = '0;
                        n_dmode = code[1:0];
                        n_dpos  = '0;
                        if (code[1:0] == 2'b11) begin
                            cmd.status = lzd_pkg::ST_MODE;
                            n_phase    = blk_end ? PH_HEADER : PH_DRAIN;
                        end else if (blk_end) begin
                            do_trunc = 1'b1;
                        end else begin
                            n_phase = code[2] ? PH_EXT : PH_DIST;
                        end
                    end
                end
                PH_EXT: begin
                    n_src_left = r_src_left - SW'(1);
                    n_len      = r_len | (LW'(b) << 5);
                    if (blk_end) do_trunc = 1'b1;
                    else n_phase = PH_DIST;
                end
                PH_DIST: begin
                    n_src_left = r_src_left - SW'(1);
                    n_dist     = dist_or;
                    if (r_dpos == r_dmode) begin
                        n_len  = r_len + LW'(4);
                        n_dist = dist_fin;
                        if (dist_fin > DW'(r_filled)) begin
                            cmd.status = lzd_pkg::ST_FAR;
                            n_phase    = blk_end ? PH_HEADER : PH_DRAIN;
                        end else begin
                            n_phase = PH_COPY;
                        end
                    end else begin
                        n_dpos = r_dpos + 2'd1;
                        if (blk_end) do_trunc = 1'b1;
                    end
                end
                PH_COPY: begin
                    cmd.status = lzd_pkg::ST_BUSY;
                end
                PH_DRAIN: begin
                    n_src_left = r_src_left - SW'(1);
                    if (blk_end) n_phase = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end

        if (do_plain) begin
            cmd.status  = lzd_pkg::ST_BYTE;
            cmd.data    = b;
            cmd.last    = blk_end;
            cmd.hist_wr = 1'b1;
            hist_push   = 1'b1;
            n_phase     = blk_end ? PH_HEADER : PH_PLAIN;
        end
        if (do_trunc) begin
            cmd.status = lzd_pkg::ST_TRUNC;
            n_phase    = PH_HEADER;
        end
        // decoded byte count saturates at the window size
        if (hist_push && (r_filled < FW'(WINDOW_DEPTH))) n_filled = r_filled + FW'(1);
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= '0;
            r_src_left <= '0;
            r_key      <= '0;
            r_dmode    <= '0;
            r_dpos     <= '0;
            r_len      <= '0;
            r_dist     <= '0;
            r_filled   <= '0;
        end else if (i_valid) begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_src_left <= n_src_left;
            r_key      <= n_key;
            r_dmode    <= n_dmode;
            r_dpos     <= n_dpos;
            r_len      <= n_len;
            r_dist     <= n_dist;
            r_filled   <= n_filled;
        end
    end

endmodule

`default_nettype wire

FILE: src/lzd_back.sv
// history window: match reads, byte writes and the result stage
`default_nettype none

module lzd_back #(
    parameter int WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lzd_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    input  wire logic           i_out_full,
    output logic                o_out_push,
    output lzd_pkg::t_out_item  o_out
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = AW + 1;
    localparam int DW = lzd_pkg::DIST_W;

    logic [7:0]    r_hist [WINDOW_DEPTH];
    logic [AW-1:0] r_wp, r_y_wa, wp_next, rd_addr;
    logic          r_y_v;
    lzd_pkg::t_cmd r_y;
    logic [7:0]    r_rdata, r_fwdv, y_val;
    logic          r_fwd, en, pop, fwd;
    logic [FW-1:0] rd_sum, rd_dist;

    assign en      = !r_y_v || !i_out_full;
    assign pop     = en && !i_cmd_empty;
    assign wp_next = (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + AW'(1);

    // read address is write pointer minus distance, modulo the window
    assign rd_dist = FW'(i_cmd.distance);
    assign rd_sum  = {1'b0, r_wp} + FW'(WINDOW_DEPTH) - rd_dist;
    assign rd_addr = (rd_sum >= FW'(WINDOW_DEPTH)) ? AW'(rd_sum - FW'(WINDOW_DEPTH))
                                                   : AW'(rd_sum);

    // distance one reads the byte still sitting in the result stage
    assign fwd   = r_y_v && r_y.hist_wr && (i_cmd.distance == DW'(1));
    assign y_val = r_y.from_mem ? (r_fwd ? r_fwdv : r_rdata) : r_y.data;

    assign o_cmd_pop       = pop;
    assign o_out_push      = en && r_y_v;
    assign o_out.status    = r_y.status;
    assign o_out.out_byte  = y_val;
    assign o_out.last      = r_y.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
            r_wp  <= '0;
        end else begin
            if (en) r_y_v <= pop;
            if (pop && i_cmd.hist_wr) r_wp <= wp_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_y    <= i_cmd;
            r_y_wa <= r_wp;
            r_fwd  <= fwd;
            r_fwdv <= y_val;
            if (i_cmd.from_mem) r_rdata <= r_hist[rd_addr];
        end
        if (en && r_y_v && r_y.hist_wr) r_hist[r_y_wa] <= y_val;
    end

endmodule

`default_nettype wire

FILE: src/escape_coded_lz_decompressor.sv
// top level: parser, command queue, history window and result queue
// path: a result goes from its item transfer through the parser into the command queue,
//   then through the history read stage, then into the result queue
// throughput: one item per cycle while the command queue has room, set by the single write
//   and single read port of the history window; match bytes of distance one are forwarded around it
// reset: synchronous active low, clears parser state and both queues; history is not cleared
`default_nettype none

module escape_coded_lz_decompressor #(
    parameter int WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // item side
    input  wire logic               push,
    output logic                    full,
    input  wire lzd_pkg::t_in_item  i_item,
    // result side
    output logic                    empty,
    input  wire logic               pop,
    output lzd_pkg::t_out_item      o_result
);

    localparam int CMD_W = $bits(lzd_pkg::t_cmd);
    localparam int OUT_W = $bits(lzd_pkg::t_out_item);

    logic               in_xfer;
    lzd_pkg::t_cmd      front_cmd, head_cmd;
    logic [CMD_W-1:0]   head_bits;
    logic               cmd_full, cmd_empty, cmd_pop;
    logic               out_full, out_push;
    lzd_pkg::t_out_item back_out;
    logic [OUT_W-1:0]   out_bits;

    // an item transfer happens when push is high and the command queue has room
    assign in_xfer = push && !cmd_full;
    assign full    = cmd_full;

    // front: parses the stream and turns every item into one command
    lzd_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_item  (i_item),
        .o_cmd   (front_cmd)
    );

    // short queue so the parser and the history side stall on their own
    lzd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (lzd_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (head_bits),
        .o_empty (cmd_empty)
    );

    assign head_cmd = lzd_pkg::t_cmd'(head_bits);

    // back: history window reads and writes, fills in match bytes
    lzd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (back_out)
    );

    // result queue decouples the consumer from the history pipeline
    lzd_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (lzd_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_out),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_bits),
        .o_empty (empty)
    );

    assign o_result = lzd_pkg::t_out_item'(out_bits);

    // only a decoded byte carries data or the end-of-block flag
    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status != lzd_pkg::ST_BYTE))
            |-> (o_result.out_byte == 8'd0 && !o_result.last))
        else $error("non-byte result carries data or last");

    // commands that write the window are always decoded bytes
    a_hist_wr_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && front_cmd.hist_wr) |-> (front_cmd.status == lzd_pkg::ST_BYTE))
        else $error("window write from a non-byte command");

    // a command read from memory is always a window write
    a_mem_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!cmd_empty && head_cmd.from_mem) |-> head_cmd.hist_wr)
        else $error("match read without window write");

    // reset leaves both sides of the block empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

`default_nettype wire
